[sv/bp_pkg.sv]
// ----------------------------------------------------------------------------
// bp_pkg: shared types and constants of the buffer recycle pool
// Opcodes, result status codes, register indexes and the command word that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bp_pkg;

  localparam int unsigned DATA_W = 32;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_DRAIN = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_HIT     = 3'd0,
    STAT_MISS    = 3'd1,
    STAT_POOLED  = 3'd2,
    STAT_RELEASE = 3'd3,
    STAT_NULL    = 3'd4,
    STAT_DRAINED = 3'd5,
    STAT_EMPTY   = 3'd6
  } status_e;

  // Command kinds after classification
  typedef enum logic [2:0] {
    KIND_ALLOC = 3'd0,
    KIND_FREE  = 3'd1,
    KIND_NULL  = 3'd2,
    KIND_BIG   = 3'd3,
    KIND_DRAIN = 3'd4
  } kind_e;

  // Configuration register indexes
  typedef enum logic {
    REG_MAX_SINGLE = 1'b0,
    REG_POOL_LIMIT = 1'b1
  } reg_e;

  localparam logic [DATA_W-1:0] MAX_SINGLE_RST = 32'd67108864;
  localparam logic [3:0]        POOL_LIMIT_RST = 4'd8;

  // Classified request handed to the back end
  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] handle;
  } cmd_t;

endpackage

`default_nettype wire

[sv/bp_ram.sv]
// ----------------------------------------------------------------------------
// bp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/bp_front.sv]
// ----------------------------------------------------------------------------
// bp_front: request intake and classification
// Holds the configuration registers, accepts requests and sorts frees into
// null, oversized and poolable before handing them to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration write port
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_addr_i,
  input  wire logic [bp_pkg::DATA_W-1:0]  cfg_wdata_i,
  // request stream
  input  wire logic                       s_valid_i,
  output logic                            s_ready_o,
  input  wire logic [1:0]                 s_opcode_i,
  input  wire logic [bp_pkg::DATA_W-1:0]  s_size_i,
  input  wire logic [bp_pkg::DATA_W-1:0]  s_handle_i,
  // command queue
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output bp_pkg::cmd_t                    q_cmd_o,
  // to back end
  output logic [3:0]                      pool_limit_o
);
  import bp_pkg::*;

  logic [DATA_W-1:0] max_single_q;
  logic [3:0]        pool_limit_q;
  op_e               op;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_single_q <= MAX_SINGLE_RST;
      pool_limit_q <= POOL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_MAX_SINGLE: max_single_q <= cfg_wdata_i;
        REG_POOL_LIMIT: pool_limit_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign pool_limit_o = pool_limit_q;
  assign op           = op_e'(s_opcode_i);

  // Accept whenever the queue has room; drop the unused opcode
  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && s_ready_o && (op != OP_NONE);

  // Classify the request
  always_comb begin
    q_cmd_o.size   = s_size_i;
    q_cmd_o.handle = s_handle_i;
    unique case (op)
      OP_ALLOC: q_cmd_o.kind = KIND_ALLOC;
      OP_FREE: begin
        priority if (s_handle_i == '0) begin
          q_cmd_o.kind = KIND_NULL;
        end else if (s_size_i > max_single_q) begin
          q_cmd_o.kind = KIND_BIG;
        end else begin
          q_cmd_o.kind = KIND_FREE;
        end
      end
      OP_DRAIN: q_cmd_o.kind = KIND_DRAIN;
      default:  q_cmd_o.kind = KIND_ALLOC;
    endcase
  end

endmodule

`default_nettype wire

[sv/bp_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// bp_cmd_fifo: two-entry command queue
// Decouples request intake from pool execution so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_cmd_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire bp_pkg::cmd_t data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output bp_pkg::cmd_t      data_o
);
  import bp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("command queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("push into full command queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("pop from empty command queue");

endmodule

`default_nettype wire

[sv/bp_back.sv]
// ----------------------------------------------------------------------------
// bp_back: pool execution engine
// Runs one command at a time against the entry RAM: appends frees, scans for
// an alloc match one entry per cycle, refills a taken slot with the last
// entry, and drains the pool. Results leave through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_back #(
  parameter int unsigned POOL_DEPTH = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [3:0]                pool_limit_i,
  // command queue
  input  wire logic                      cmd_valid_i,
  input  wire bp_pkg::cmd_t              cmd_i,
  output logic                           cmd_pop_o,
  // result stream
  output logic                           m_valid_o,
  input  wire logic                      m_ready_i,
  output logic [2:0]                     m_status_o,
  output logic [bp_pkg::DATA_W-1:0]      m_handle_o,
  output logic [bp_pkg::DATA_W-1:0]      m_capacity_o,
  output logic                           m_last_o
);
  import bp_pkg::*;

  localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CMP_W = 8;
  localparam int unsigned WORD_W = 2 * DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_HIT   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [DATA_W-1:0] size_q, size_d;
  logic [DATA_W-1:0] hit_handle_q, hit_handle_d;
  logic [DATA_W-1:0] hit_cap_q, hit_cap_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_handle_q;
  logic [DATA_W-1:0] out_cap_q;
  logic              out_last_q;
  logic              out_free;

  logic              emit;
  status_e           emit_status;
  logic [DATA_W-1:0] emit_handle;
  logic [DATA_W-1:0] emit_cap;
  logic              emit_last;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [DATA_W-1:0] rd_handle;
  logic [DATA_W-1:0] rd_cap;

  logic [IDX_W-1:0]  last_idx;
  logic              can_pool;
  logic              cap_hit;

  // Entry store: capacity in the upper half, handle in the lower half
  bp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (POOL_DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_handle = ram_rdata[DATA_W-1:0];
  assign rd_cap    = ram_rdata[WORD_W-1:DATA_W];
  assign last_idx  = IDX_W'(count_q - 1'b1);
  assign out_free  = !out_valid_q || m_ready_i;

  // Room for one more entry under both the limit and the depth
  assign can_pool = (CMP_W'(count_q) < CMP_W'(pool_limit_i)) &&
                    (CMP_W'(count_q) < CMP_W'(POOL_DEPTH));

  // size <= capacity < 2 * size, at full width
  assign cap_hit = (rd_cap >= size_q) && ({1'b0, rd_cap} < {size_q, 1'b0});

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    size_d       = size_q;
    hit_handle_d = hit_handle_q;
    hit_cap_d    = hit_cap_q;
    cmd_pop_o    = 1'b0;
    emit         = 1'b0;
    emit_status  = STAT_MISS;
    emit_handle  = '0;
    emit_cap     = '0;
    emit_last    = 1'b1;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IDX_W-1:0];
    ram_wdata    = {cmd_i.size, cmd_i.handle};
    ram_raddr    = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = '0;
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          size_d    = cmd_i.size;
          idx_d     = '0;
          unique case (cmd_i.kind)
            KIND_ALLOC: begin
              if (cmd_i.size == '0 || count_q == '0) begin
                emit        = 1'b1;
                emit_status = STAT_MISS;
              end else begin
                state_d = ST_SCAN;
              end
            end
            KIND_NULL: begin
              emit        = 1'b1;
              emit_status = STAT_NULL;
            end
            KIND_BIG: begin
              emit        = 1'b1;
              emit_status = STAT_RELEASE;
              emit_handle = cmd_i.handle;
            end
            KIND_FREE: begin
              emit = 1'b1;
              if (can_pool) begin
                ram_we      = 1'b1;
                count_d     = count_q + 1'b1;
                emit_status = STAT_POOLED;
              end else begin
                emit_status = STAT_RELEASE;
                emit_handle = cmd_i.handle;
              end
            end
            KIND_DRAIN: begin
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                state_d = ST_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        priority if (cap_hit) begin
          // hold the taken entry, fetch the last one to refill the slot
          hit_handle_d = rd_handle;
          hit_cap_d    = rd_cap;
          ram_raddr    = last_idx;
          state_d      = ST_HIT;
        end else if (idx_q == last_idx) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = STAT_MISS;
            state_d     = ST_IDLE;
          end
        end else begin
          idx_d     = idx_q + 1'b1;
          ram_raddr = idx_q + 1'b1;
        end
      end

      ST_HIT: begin
        ram_raddr = last_idx;
        if (out_free) begin
          ram_we      = 1'b1;
          ram_waddr   = idx_q;
          ram_wdata   = ram_rdata;
          count_d     = count_q - 1'b1;
          emit        = 1'b1;
          emit_status = STAT_HIT;
          emit_handle = hit_handle_q;
          emit_cap    = hit_cap_q;
          state_d     = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = STAT_DRAINED;
          emit_handle = rd_handle;
          emit_cap    = rd_cap;
          emit_last   = (idx_q == last_idx);
          if (idx_q == last_idx) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d     = idx_q + 1'b1;
            ram_raddr = idx_q + 1'b1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    size_q       <= size_d;
    hit_handle_q <= hit_handle_d;
    hit_cap_q    <= hit_cap_d;
    if (out_free && emit) begin
      out_status_q <= emit_status;
      out_handle_q <= emit_handle;
      out_cap_q    <= emit_cap;
      out_last_q   <= emit_last;
    end
  end

  assign m_valid_o    = out_valid_q;
  assign m_status_o   = out_status_q;
  assign m_handle_o   = out_handle_q;
  assign m_capacity_o = out_cap_q;
  assign m_last_o     = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(POOL_DEPTH)) else $error("entry count above pool depth");

  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_HIT || state_q == ST_DRAIN)
      |-> count_q != '0) else $error("pool walk with no entries");

  a_hit_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HIT && out_free) |=> count_q == $past(count_q) - 1'b1)
    else $error("alloc hit did not remove an entry");

endmodule

`default_nettype wire

[sv/buffer_recycle_pool_top.sv]
// ----------------------------------------------------------------------------
// buffer_recycle_pool_top: pool of returned buffers (handle + capacity)
// Alloc takes the first entry with size <= capacity < 2*size, free appends or
// releases, cleanup drains every held entry.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue and are executed one at a time
// against an entry RAM with a single registered read port, so the walk
// through entries reads them one after another. A free, a null free and an
// oversized free are answered without a walk. An alloc misses at once when
// the pool is empty or the size is zero; otherwise it scans the entries in
// order, refills the slot of a hit from the last entry, and misses after
// the last entry. Cleanup emits one result per entry, last flagged; on an
// empty pool it emits a single "drain empty" result. Opcode 3 is accepted
// and dropped without a result. Configuration writes take effect at once
// and are expected only while the block is idle.
`default_nettype none

module buffer_recycle_pool_top #(
  parameter int unsigned POOL_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: index 0 max_single_size, index 1 pool_limit
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [31:0] req_size, [63:32] handle
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // [31:0] out_handle, [63:32] out_capacity
  output logic [2:0]       m_axis_tuser_o,   // [2:0] status
  output logic             m_axis_tlast_o
);
  import bp_pkg::*;

  logic        q_full;
  logic        q_push;
  cmd_t        q_cmd_in;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_cmd_out;
  logic [3:0]  pool_limit;

  // Intake and classification
  bp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_opcode_i   (s_axis_tuser_i),
    .s_size_i     (s_axis_tdata_i[31:0]),
    .s_handle_i   (s_axis_tdata_i[63:32]),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd_in),
    .pool_limit_o (pool_limit)
  );

  // Command queue between intake and execution
  bp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd_out)
  );

  // Pool execution
  bp_back #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pool_limit_i (pool_limit),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd_out),
    .cmd_pop_o    (q_pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_status_o   (m_axis_tuser_o),
    .m_handle_o   (m_axis_tdata_o[31:0]),
    .m_capacity_o (m_axis_tdata_o[63:32]),
    .m_last_o     (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[tb/bp_checker.sv]
// ----------------------------------------------------------------------------
// bp_checker: result checker of the buffer recycle pool
// Watches the register port and both stream channels, keeps its own copy of
// the pool, predicts the results of every accepted request and compares each
// accepted result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module bp_checker #(
  parameter int unsigned POOL_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // register port as seen by the block
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i,
  // request channel
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [63:0] s_axis_tdata_i,   // [31:0] req_size, [63:32] handle
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  // result channel
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [63:0] m_axis_tdata_i,   // [31:0] out_handle, [63:32] out_capacity
  input  wire logic [2:0]  m_axis_tuser_i,   // [2:0] status
  input  wire logic        m_axis_tlast_i,
  // totals for the testbench top
  output int               errors_o,
  output int               pending_o,
  output int               results_o,
  output int               hits_o,
  output int               drained_o
);

  import bp_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [31:0] handle;
    logic [31:0] capacity;
    logic        last;
  } pool_result_t;

  // predicted results not yet seen on the result channel
  pool_result_t expected_results[$];

  // shadow copy of the pool and its registers
  logic [31:0] shadow_handle   [POOL_DEPTH];
  logic [31:0] shadow_capacity [POOL_DEPTH];
  int unsigned shadow_count;
  logic [31:0] shadow_max_single;
  logic [3:0]  shadow_limit;

  int n_errors;
  int n_results;
  int n_hits;
  int n_drained;

  function automatic pool_result_t make_result(status_e st, logic [31:0] hdl,
                                               logic [31:0] cap, logic lst);
    pool_result_t r;
    r.status   = st;
    r.handle   = hdl;
    r.capacity = cap;
    r.last     = lst;
    return r;
  endfunction

  // Append one prediction at the tail of the queue
  function automatic void queue_expected(pool_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Apply one request to the shadow pool and queue the results it causes
  task automatic predict_pool_op(op_e op, logic [31:0] size, logic [31:0] hdl);
    logic [32:0] lo;
    logic [32:0] hi;
    int unsigned limit_eff;
    bit          found;
    lo    = {1'b0, size};
    hi    = {size, 1'b0};
    found = 1'b0;
    case (op)
      OP_ALLOC: begin
        // first fit with capacity in [size, 2*size); refill slot from the tail
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (!found && {1'b0, shadow_capacity[i]} >= lo &&
              {1'b0, shadow_capacity[i]} < hi) begin
            queue_expected(make_result(STAT_HIT, shadow_handle[i],
                                       shadow_capacity[i], 1'b1));
            shadow_handle[i]   = shadow_handle[shadow_count-1];
            shadow_capacity[i] = shadow_capacity[shadow_count-1];
            shadow_count--;
            found = 1'b1;
          end
        end
        if (!found) begin
          queue_expected(make_result(STAT_MISS, '0, '0, 1'b1));
        end
      end
      OP_FREE: begin
        limit_eff = (shadow_limit > POOL_DEPTH) ? POOL_DEPTH : shadow_limit;
        if (hdl == '0) begin
          queue_expected(make_result(STAT_NULL, '0, '0, 1'b1));
        end else if (size > shadow_max_single || shadow_count >= limit_eff) begin
          queue_expected(make_result(STAT_RELEASE, hdl, '0, 1'b1));
        end else begin
          shadow_handle[shadow_count]   = hdl;
          shadow_capacity[shadow_count] = size;
          shadow_count++;
          queue_expected(make_result(STAT_POOLED, '0, '0, 1'b1));
        end
      end
      OP_DRAIN: begin
        if (shadow_count == 0) begin
          queue_expected(make_result(STAT_EMPTY, '0, '0, 1'b1));
        end else begin
          for (int unsigned i = 0; i < shadow_count; i++) begin
            queue_expected(make_result(STAT_DRAINED, shadow_handle[i],
                                       shadow_capacity[i],
                                       i == shadow_count - 1));
          end
          shadow_count = 0;
        end
      end
      default: begin
        // unused opcode: no state change, no result
      end
    endcase
  endtask

  task automatic report_error(string what, pool_result_t want, pool_result_t got);
    if (n_errors < 10) begin
      $display("[%0t] %s: expected status %0d handle %h cap %h last %0b,",
               $time, what, want.status, want.handle, want.capacity, want.last);
      $display("    got status %0d handle %h cap %h last %0b",
               got.status, got.handle, got.capacity, got.last);
    end
    n_errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t got;
    pool_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      shadow_count      = 0;
      shadow_max_single = MAX_SINGLE_RST;
      shadow_limit      = POOL_LIMIT_RST;
      n_errors          = 0;
      n_results         = 0;
      n_hits            = 0;
      n_drained         = 0;
    end else begin
      // check the result accepted at this edge against the oldest prediction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status   = status_e'(m_axis_tuser_i);
        got.handle   = m_axis_tdata_i[31:0];
        got.capacity = m_axis_tdata_i[63:32];
        got.last     = m_axis_tlast_i;
        n_results++;
        if (got.status == STAT_HIT) n_hits++;
        if (got.status == STAT_DRAINED) n_drained++;
        if (expected_results.size() == 0) begin
          report_error("unexpected result", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) report_error("result mismatch", want, got);
        end
      end
      // predict the request accepted at this edge
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_pool_op(op_e'(s_axis_tuser_i), s_axis_tdata_i[31:0],
                        s_axis_tdata_i[63:32]);
      end
      // track register writes
      if (cfg_we_i) begin
        case (reg_e'(cfg_addr_i))
          REG_MAX_SINGLE: shadow_max_single = cfg_wdata_i;
          REG_POOL_LIMIT: shadow_limit      = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
    end
    errors_o  <= n_errors;
    pending_o <= expected_results.size();
    results_o <= n_results;
    hits_o    <= n_hits;
    drained_o <= n_drained;
  end

endmodule

`default_nettype wire

[tb/buffer_recycle_pool_top_tb.sv]
// ----------------------------------------------------------------------------
// buffer_recycle_pool_top_tb: testbench of the buffer recycle pool
// Drives directed corner requests, then mostly free-then-alloc runs mixed with
// noise under several register settings, with bursty requests and a stalling
// result receiver. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_recycle_pool_top_tb;

  import bp_pkg::*;

  localparam int unsigned POOL_DEPTH    = 8;
  localparam int unsigned SETTLE_CYCLES = 2 * POOL_DEPTH + 8;
  localparam int unsigned STALL_LIMIT   = 4000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  reg_e        cfg_addr  = REG_MAX_SINGLE;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic [63:0] s_tdata   = '0;
  op_e         s_tuser   = OP_NONE;
  logic        m_tready  = 1'b0;

  wire logic        s_tready;
  wire logic        m_tvalid;
  wire logic [63:0] m_tdata;
  wire logic [2:0]  m_tuser;
  wire logic        m_tlast;

  int errors;
  int pending;
  int n_results;
  int n_hits;
  int n_drained;

  // stimulus bookkeeping
  logic [31:0] cur_max   = MAX_SINGLE_RST;
  int          burst_left = 0;
  bit          no_gaps    = 1'b0;
  int          op_count[4];
  int          n_settings = 1;
  int          idle_cycles = 0;

  buffer_recycle_pool_top #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  bp_checker #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (n_results),
    .hits_o          (n_hits),
    .drained_o       (n_drained)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: switch between always ready, light, heavy and long stalls
  int unsigned ready_mode = 0;
  int unsigned mode_left  = 0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(32, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no traffic for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one request; open a new burst, maybe after a gap, when the last ends
  task automatic send_req(op_e op, logic [31:0] size, logic [31:0] hdl);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {hdl, size};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    op_count[op]++;
  endtask

  // Hold requests until every predicted result has come, then let the engine settle
  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] max_single, logic [3:0] limit);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MAX_SINGLE;
    cfg_wdata <= max_single;
    @(posedge clk_i);
    cfg_addr  <= REG_POOL_LIMIT;
    cfg_wdata <= {28'd0, limit};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_max   = max_single;
    n_settings++;
  endtask

  function automatic logic [31:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom();
      2:       return cur_max;
      3:       return cur_max + 32'd1;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic logic [31:0] pick_handle();
    if ($urandom_range(0, 9) == 0) return 32'd0;
    return $urandom();
  endfunction

  // Size that fits a capacity: in (cap/2, cap], sometimes plain noise
  function automatic logic [31:0] fit_size(logic [31:0] cap);
    if (cap == 32'd0) return $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return cap - $urandom_range(0, (cap - 32'd1) / 2);
  endfunction

  // Mostly return-then-reuse runs with random content, the rest loose noise
  task automatic random_phase(int n_items);
    logic [31:0] caps[POOL_DEPTH];
    int          sent;
    int          n_run;
    op_e         op;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        n_run = $urandom_range(1, POOL_DEPTH);
        for (int k = 0; k < n_run; k++) begin
          caps[k] = pick_capacity();
          send_req(OP_FREE, caps[k], pick_handle());
        end
        repeat (n_run) begin
          send_req(OP_ALLOC, fit_size(caps[$urandom_range(0, n_run - 1)]), $urandom());
        end
        sent += 2 * n_run;
        if ($urandom_range(0, 5) == 0) begin
          send_req(OP_DRAIN, $urandom(), $urandom());
          sent++;
        end
      end else begin
        op = op_e'($urandom_range(0, 3));
        send_req(op, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 400),
                 pick_handle());
        if (op != OP_NONE) sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners under the reset settings
    send_req(OP_DRAIN, 32'd0, 32'd0);                    // cleanup of an empty pool
    send_req(OP_ALLOC, 32'd0, 32'd0);                    // alloc on an empty pool
    send_req(OP_FREE, 32'd100, 32'd0);                   // null free
    send_req(OP_FREE, 32'hFFFF_FFFF, 32'd0);             // null free, huge size
    send_req(OP_FREE, MAX_SINGLE_RST + 32'd1, 32'hFFFF_FFFF); // oversized release
    send_req(OP_FREE, MAX_SINGLE_RST, 32'hFFFF_FFFF);    // exactly at the limit
    send_req(OP_FREE, 32'd100, 32'd1);
    send_req(OP_FREE, 32'd200, 32'd2);
    send_req(OP_FREE, 32'd1, 32'd3);
    send_req(OP_FREE, 32'd0, 32'd4);                     // zero capacity is pooled
    send_req(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);            // zero size never hits
    send_req(OP_ALLOC, 32'd100, 32'd0);                  // hit, slot refilled from tail
    send_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);            // doubled size beyond 32 bits
    send_req(OP_ALLOC, 32'h8000_0000, 32'd0);
    send_req(OP_ALLOC, 32'd33554432, 32'd0);             // capacity equal to twice size
    send_req(OP_ALLOC, 32'd33554433, 32'd0);             // just inside the window
    send_req(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);     // unused opcode
    send_req(OP_ALLOC, 32'd1, 32'd0);
    for (int i = 0; i < 6; i++) begin
      send_req(OP_FREE, 32'd10 + i, 32'h100 + i);        // fill the pool
    end
    send_req(OP_FREE, 32'd7, 32'hABCD);                  // pool full: release
    send_req(OP_DRAIN, 32'd0, 32'd0);                    // full drain
    send_req(OP_ALLOC, 32'd5, 32'd0);
    wait_idle();

    // random phases over several settings, extremes included
    set_config(32'hFFFF_FFFF, 4'd15);
    random_phase(100);
    wait_idle();
    set_config(32'd0, 4'd0);
    random_phase(60);
    wait_idle();
    set_config(32'd1000, 4'd3);
    random_phase(90);
    wait_idle();
    set_config($urandom(), 4'd9);
    random_phase(70);
    wait_idle();
    no_gaps = 1'b1;
    set_config(MAX_SINGLE_RST, 4'd1);
    random_phase(60);
    wait_idle();
    no_gaps = 1'b0;
    set_config(32'd250, 4'd8);
    random_phase(80);
    wait_idle();

    $display("Covered %0d alloc, %0d free, %0d cleanup and %0d unused requests over %0d settings",
             op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_DRAIN],
             op_count[OP_NONE], n_settings);
    $display("Checked %0d results, %0d of them alloc hits and %0d drained entries",
             n_results, n_hits, n_drained);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/bp_pkg.sv
sv/bp_ram.sv
sv/bp_front.sv
sv/bp_cmd_fifo.sv
sv/bp_back.sv
sv/buffer_recycle_pool_top.sv
tb/bp_checker.sv
tb/buffer_recycle_pool_top_tb.sv
